// ===== hdl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// No dependencies; imported by the cell and the top level.
package swm_pkg;

  // Sample positions and the window size register are 7 bits wide.
  localparam int PosW = 7;
  localparam int WsW  = 7;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [WsW-1:0]  ws_t;

  // Status one cell shows its neighbors: the slot holds a candidate, and that
  // candidate is not smaller than the sample being taken in.
  typedef struct packed {
    logic valid;
    logic ge;
  } swm_flags_t;

endpackage

// ===== hdl/swm_cell.sv =====
// One slot of the candidate queue: a value, its sample position and a valid bit.
// Depends on swm_pkg. Instantiated once per slot by sliding_window_maximum.
module swm_cell import swm_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         clr_i,
  input  logic                         shift_i,
  input  logic signed [DATA_WIDTH-1:0] sample_i,
  input  pos_t                         position_i,
  input  logic                         prev_keep_i,
  input  swm_flags_t                   nxt_flags_i,
  input  logic signed [DATA_WIDTH-1:0] nxt_value_i,
  input  pos_t                         nxt_pos_i,
  output swm_flags_t                   flags_o,
  output logic signed [DATA_WIDTH-1:0] value_o,
  output pos_t                         pos_o,
  output logic                         keep_o
);

  logic                         valid_q, valid_d;
  logic signed [DATA_WIDTH-1:0] value_q, value_d;
  pos_t                         pos_q, pos_d;
  swm_flags_t                   src_flags;

  // A candidate that is not smaller than the new sample survives the back pops.
  assign flags_o.valid = valid_q;
  assign flags_o.ge    = (value_q >= sample_i);
  assign value_o       = value_q;
  assign pos_o         = pos_q;

  // The slot either keeps its own candidate or takes its neighbor's one.
  assign src_flags = shift_i ? nxt_flags_i : flags_o;
  assign keep_o    = src_flags.valid & src_flags.ge;

  // The new sample lands in the first slot that holds no surviving candidate.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    pos_d   = pos_q;
    if (en_i) begin
      if (keep_o) begin
        valid_d = 1'b1;
        value_d = shift_i ? nxt_value_i : value_q;
        pos_d   = shift_i ? nxt_pos_i : pos_q;
      end else if (prev_keep_i) begin
        valid_d = 1'b1;
        value_d = sample_i;
        pos_d   = position_i;
      end else begin
        valid_d = 1'b0;
      end
      if (clr_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

endmodule

// ===== hdl/sliding_window_maximum.sv =====
// A result appears on the output register in the cycle after its item is taken.
// Throughput: one item per cycle; the input stalls only while a result waits downstream.
// All queue slots update in parallel in the cell row.
// Reset clears the slot valid bits, position, fill count and output valid at once,
// and sets window_size to 1; no clearing pass is needed.
// Depends on swm_pkg and swm_cell.
module sliding_window_maximum import swm_pkg::*; #(
  parameter int WINDOW_MAX = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  ws_t                          cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] sample_i,
  input  logic                         last_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] window_max_o
);

  // Largest window the 7-bit register can ask for that the queue can hold.
  localparam int  WinCap  = (WINDOW_MAX > 127) ? 127 : WINDOW_MAX;
  localparam ws_t WinCapW = ws_t'(WinCap);

  ws_t                          window_size_q;
  ws_t                          win_eff;
  pos_t                         position_q, position_d;
  ws_t                          fill_q, fill_d, fill_next;
  logic                         out_valid_q, out_valid_d;
  logic signed [DATA_WIDTH-1:0] window_max_q, window_max_d;
  logic                         accept;
  logic                         front_pop;
  logic                         full_pop;
  logic                         shift;
  logic                         emit;
  pos_t                         age;
  logic signed [DATA_WIDTH-1:0] front_value;

  swm_flags_t                   flags [WINDOW_MAX+1];
  logic signed [DATA_WIDTH-1:0] values [WINDOW_MAX+1];
  pos_t                         poss [WINDOW_MAX+1];
  logic                         keeps [WINDOW_MAX+1];

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= ws_t'(1);
    end else if (cfg_valid_i) begin
      window_size_q <= cfg_data_i;
    end
  end

  // Zero behaves as one; sizes above the queue depth are capped.
  always_comb begin
    if (window_size_q == '0) begin
      win_eff = ws_t'(1);
    end else if (window_size_q > WinCapW) begin
      win_eff = WinCapW;
    end else begin
      win_eff = window_size_q;
    end
  end

  // Handshake: a waiting result that is not taken holds the input.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Front candidate leaves once its age reaches the window size.
  assign age       = position_q - poss[0];
  assign front_pop = flags[0].valid & (age >= win_eff);
  // A full queue with nothing popped drops its front to make room.
  assign full_pop  = ~front_pop & flags[WINDOW_MAX-1].valid & flags[WINDOW_MAX-1].ge;
  assign shift     = front_pop | full_pop;

  // Tie-off past the end of the row.
  assign flags[WINDOW_MAX]  = '0;
  assign values[WINDOW_MAX] = '0;
  assign poss[WINDOW_MAX]   = '0;
  assign keeps[0]           = 1'b1;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .clr_i      (last_sample_i),
      .shift_i    (shift),
      .sample_i   (sample_i),
      .position_i (position_q),
      .prev_keep_i(keeps[i]),
      .nxt_flags_i(flags[i+1]),
      .nxt_value_i(values[i+1]),
      .nxt_pos_i  (poss[i+1]),
      .flags_o    (flags[i]),
      .value_o    (values[i]),
      .pos_o      (poss[i]),
      .keep_o     (keeps[i+1])
    );
  end

  // Front of the queue after this item's update.
  always_comb begin
    if (keeps[1]) begin
      front_value = shift ? values[1] : values[0];
    end else begin
      front_value = sample_i;
    end
  end

  // Fill count saturates at the window size; a result needs a full window.
  assign fill_next = (fill_q < win_eff) ? fill_q + ws_t'(1) : win_eff;
  assign emit      = (fill_next == win_eff);

  always_comb begin
    position_d = position_q;
    fill_d     = fill_q;
    if (accept) begin
      position_d = position_q + pos_t'(1);
      fill_d     = fill_next;
      if (last_sample_i) begin
        position_d = '0;
        fill_d     = '0;
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d  = out_valid_q;
    window_max_d = window_max_q;
    if (accept && emit) begin
      out_valid_d  = 1'b1;
      window_max_d = front_value;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      position_q  <= position_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    window_max_q <= window_max_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = window_max_q;

endmodule

// ===== hdl/swm_checker.sv =====
// Port-level checks for sliding_window_maximum, attached by the bind below.
// Depends on swm_pkg and on the top level's ports only.
module swm_checker import swm_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input ws_t                          cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic signed [DATA_WIDTH-1:0] sample_i,
  input logic                         last_sample_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [DATA_WIDTH-1:0] window_max_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_max_o))
    else $error("stalled result changed");

  // A fresh result follows an item accepted in the cycle before.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o && out_stall_i) |->
      $past(in_valid_i && !in_stall_o))
    else $error("result without an accepted item");

  // The input only stalls while a result is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no waiting result");

  // The configuration port never blocks.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind sliding_window_maximum swm_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_swm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .cfg_data_i   (cfg_data_i),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .sample_i     (sample_i),
  .last_sample_i(last_sample_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .window_max_o (window_max_o)
);

// ===== sim/sliding_window_maximum_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_maximum: it drives sample sequences and
// window sizes, predicts every window maximum and checks each result in order.
// Depends on swm_pkg and the sliding_window_maximum RTL.
module sliding_window_maximum_test import swm_pkg::*;;

  localparam int DataW      = 32;
  localparam int WinMax     = 64;
  localparam int CycleLimit = 400000;

  typedef logic signed [DataW-1:0] sample_t;

  localparam sample_t MostNegative = {1'b1, {(DataW-1){1'b0}}};
  localparam sample_t MostPositive = {1'b0, {(DataW-1){1'b1}}};

  // Tracks the candidate queue of the block and holds the maxima still due.
  class window_max_tracker;
    sample_t     cand_value[WinMax];
    pos_t        cand_pos[WinMax];
    int unsigned cand_count;
    pos_t        seq_pos;
    int unsigned filled;
    ws_t         window_reg;
    sample_t     expected_max[$];
    int          errors;

    function new();
      cand_count = 0;
      seq_pos    = '0;
      filled     = 0;
      window_reg = ws_t'(1);
      errors     = 0;
    endfunction

    function void set_window(ws_t size);
      window_reg = size;
    endfunction

    // Window size as the block uses it: zero counts as one, large values clamp.
    function int unsigned window_used();
      int unsigned w;
      w = window_reg;
      if (w == 0) w = 1;
      if (w > WinMax) w = WinMax;
      return w;
    endfunction

    function void drop_front();
      if (cand_count == 0) return;
      for (int i = 1; i < cand_count; i++) begin
        cand_value[i-1] = cand_value[i];
        cand_pos[i-1]   = cand_pos[i];
      end
      cand_count--;
    endfunction

    // Notes an accepted item and queues the maximum it produces, if any.
    function void take_sample(sample_t s, logic last);
      int unsigned w;
      pos_t        age;
      w = window_used();
      // At most one expired candidate leaves the front per item.
      if (cand_count > 0) begin
        age = seq_pos - cand_pos[0];
        if (age >= w) drop_front();
      end
      // Smaller candidates at the back can never be a maximum again; ties stay.
      while (cand_count > 0 && cand_value[cand_count-1] < s) cand_count--;
      if (cand_count >= WinMax) drop_front();
      cand_value[cand_count] = s;
      cand_pos[cand_count]   = seq_pos;
      cand_count++;
      if (filled < w) filled++;
      if (filled > w) filled = w;
      if (filled >= w) expected_max.push_back(cand_value[0]);
      seq_pos = seq_pos + 1'b1;
      if (last) begin
        cand_count = 0;
        seq_pos    = '0;
        filled     = 0;
      end
    endfunction

    // Compares one accepted result with the oldest maximum still due.
    function void match_result(sample_t actual);
      sample_t want;
      if (expected_max.size() == 0) begin
        errors++;
        $display("%0t: window_max expected none, got %0d", $time, actual);
        return;
      end
      want = expected_max.pop_front();
      if (actual !== want) begin
        errors++;
        $display("%0t: window_max expected %0d, got %0d", $time, want, actual);
      end
    endfunction
  endclass

  logic    clk_i         = 1'b0;
  logic    rst_ni        = 1'b0;
  logic    cfg_valid_i   = 1'b0;
  logic    cfg_ready_o;
  ws_t     cfg_data_i    = '0;
  logic    in_valid_i    = 1'b0;
  logic    in_stall_o;
  sample_t sample_i      = '0;
  logic    last_sample_i = 1'b0;
  logic    out_valid_o;
  logic    out_stall_i   = 1'b0;
  sample_t window_max_o;

  int          idle_pct    = 15;
  int          stall_pct   = 77;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  window_max_tracker tracker;

  sliding_window_maximum #(
    .WINDOW_MAX(WinMax),
    .DATA_WIDTH(DataW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_max_o (window_max_o)
  );

  always #2 clk_i = ~clk_i;

  // Random back pressure on the result side.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Every result taken at this edge is checked against the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_result(window_max_o);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: no progress after %0d cycles", $time, CycleLimit);
      $display("sliding_window_maximum_test failed");
      $finish;
    end
  end

  // Offers one item, with random gaps before it, and waits until it is taken.
  task automatic send_sample(sample_t s, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_sample(s, last);
    items_sent++;
  endtask

  // Holds the input off until every due maximum has come and the block is quiet.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.expected_max.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(ws_t size);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_window(size);
  endtask

  // Mostly small values so that ties and back drops are frequent.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return MostNegative;
          1:       return MostPositive;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2:    return sample_t'($urandom);
      default: return sample_t'(int'($urandom_range(8)) - 4);
    endcase
  endfunction

  function automatic ws_t pick_window();
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(5))
          0:       return ws_t'(0);
          1:       return ws_t'(1);
          2:       return ws_t'(63);
          3:       return ws_t'(64);
          4:       return ws_t'(65);
          default: return ws_t'(127);
        endcase
      end
      1, 2:    return ws_t'($urandom_range(1, WinMax));
      default: return ws_t'($urandom_range(1, 8));
    endcase
  endfunction

  // One sequence: falling, rising or mixed values; some run past the position
  // wrap, and some stay open so the next window change lands mid-sequence.
  task automatic run_sequence();
    int unsigned w;
    int unsigned len;
    int unsigned style;
    logic        ends;
    sample_t     level;
    w     = tracker.window_used();
    style = $urandom_range(5);
    if ($urandom_range(19) == 0) len = $urandom_range(130, 200);
    else len = $urandom_range(1, 2 * w + 4);
    ends  = ($urandom_range(5) != 0);
    level = pick_sample();
    for (int i = 0; i < len; i++) begin
      sample_t s;
      case (style)
        0: begin
          level = level - sample_t'($urandom_range(2));
          s     = level;
        end
        1: begin
          level = level + sample_t'($urandom_range(2));
          s     = level;
        end
        default: s = pick_sample();
      endcase
      send_sample(s, ends && (i == len - 1));
    end
  endtask

  task automatic run_phase(int sender_idle, int receiver_stall, ws_t first_window,
                           int unsigned quota);
    int unsigned stop_at;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    stop_at   = items_sent + quota;
    write_window(first_window);
    while (items_sent < stop_at) begin
      if ($urandom_range(3) == 0) write_window(pick_window());
      run_sequence();
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Window of one after reset: every item is its own maximum.
    send_sample(MostNegative, 1'b0);
    send_sample(MostPositive, 1'b0);
    send_sample('0, 1'b1);

    // A window size of zero behaves as one.
    write_window(ws_t'(0));
    send_sample(-1, 1'b0);
    send_sample(5, 1'b1);

    // Sequence shorter than the window gives nothing; then ties and expiry.
    write_window(ws_t'(3));
    send_sample(7, 1'b0);
    send_sample(8, 1'b1);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-2, 1'b0);
    send_sample(5, 1'b0);
    send_sample(9, 1'b0);
    send_sample(-9, 1'b1);

    // Oversized window clamps to the queue depth; this short sequence gives nothing.
    write_window(ws_t'(127));
    send_sample(MostPositive, 1'b0);
    send_sample(MostNegative, 1'b1);

    // Window shrinks while a sequence is open.
    write_window(ws_t'(4));
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    send_sample(3, 1'b0);
    send_sample(4, 1'b0);
    send_sample(0, 1'b0);
    write_window(ws_t'(2));
    send_sample(6, 1'b0);
    send_sample(-6, 1'b0);
    send_sample(3, 1'b1);

    run_phase(15, 77, ws_t'(64), 400);
    run_phase(77, 15, ws_t'(65), 400);
    run_phase(0, 0, ws_t'(1), 400);

    wait_idle();
    if (tracker.expected_max.size() != 0) begin
      $display("%0t: %0d window_max results never arrived", $time,
               tracker.expected_max.size());
    end
    if (tracker.errors == 0 && tracker.expected_max.size() == 0) begin
      $display("sliding_window_maximum_test passed");
    end else begin
      $display("sliding_window_maximum_test failed");
    end
    $finish;
  end

endmodule
